// ===== design/bmcc_pkg.sv =====
package bmcc_pkg;

   // Default length of the controller chain and the widest chain supported.
   localparam int unsigned NUM_MODULES_DEF = 6;
   localparam int unsigned MOD_IDX_W       = 4;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned ADDR_W  = 20;
   localparam int unsigned IDENT_W = 8;
   localparam int unsigned COUNT_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_RESET       = 2'd0,
      CMD_CONFIGURE   = 2'd1,
      CMD_UNCONFIGURE = 2'd2,
      CMD_IDENT       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;      // capture the incoming beat
      logic exec;       // apply the captured command to the chain
      logic load_rsp;   // load the result register
   } ctrl_type;

   // Count a controller returns to on reset; controllers past the fifth hold none.
   function automatic logic [COUNT_W-1:0] count_reset(input logic [MOD_IDX_W-1:0] mod);
      logic [COUNT_W-1:0] c;
      unique case (mod)
         4'd0:    c = 2'd1;
         4'd1:    c = 2'd2;
         4'd2:    c = 2'd2;
         4'd3:    c = 2'd2;
         4'd4:    c = 2'd2;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   // Identifier of controller mod when its pending count is cnt.
   function automatic logic [IDENT_W-1:0] ident_of(input logic [MOD_IDX_W-1:0] mod,
                                                   input logic [COUNT_W-1:0]   cnt);
      logic [MOD_IDX_W+1:0] idx;
      logic [IDENT_W-1:0]   id;
      idx = {1'b0, mod, 1'b0} + {{MOD_IDX_W{1'b0}}, 2'd2 - cnt};
      unique case (idx)
         6'd4:    id = 8'h05;
         6'd5:    id = 8'hf6;
         6'd6:    id = 8'h07;
         6'd7:    id = 8'hf8;
         6'd8:    id = 8'h01;
         6'd9:    id = 8'hf2;
         default: id = 8'h00;
      endcase
      return id;
   endfunction

endpackage

// ===== design/bmcc_req_if.sv =====
interface bmcc_req_if;
   logic                        valid;
   logic                        ready;
   logic [bmcc_pkg::CMD_W-1:0]  cmd;
   logic [bmcc_pkg::ADDR_W-1:0] address;

   modport source (output valid, output cmd, output address, input ready);
   modport sink   (input valid, input cmd, input address, output ready);
endinterface

// ===== design/bmcc_rsp_if.sv =====
interface bmcc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bmcc_pkg::IDENT_W-1:0] chip_ident;
   logic                         applied;

   modport source (output valid, output chip_ident, output applied, input ready);
   modport sink   (input valid, input chip_ident, input applied, output ready);
endinterface

// ===== design/bmcc_ctrl.sv =====
module bmcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bmcc_pkg::ctrl_type  ctrl
);

   bmcc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmcc_pkg::ST_IDLE: begin
            if (req_valid) state_in = bmcc_pkg::ST_EXEC;
         end
         bmcc_pkg::ST_EXEC: begin
            state_in = bmcc_pkg::ST_FIN;
         end
         bmcc_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) state_in = bmcc_pkg::ST_IDLE;
         end
         default: begin
            state_in = bmcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      ctrl.latch    = 1'b0;
      ctrl.exec     = 1'b0;
      ctrl.load_rsp = 1'b0;
      unique case (state_ff)
         bmcc_pkg::ST_IDLE: begin
            // No beat is taken while reset is held.
            req_ready  = !reset;
            ctrl.latch = req_valid && !reset;
         end
         bmcc_pkg::ST_EXEC: begin
            ctrl.exec = 1'b1;
         end
         bmcc_pkg::ST_FIN: begin
            ctrl.load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/bmcc_datapath.sv =====
module bmcc_datapath #(
   parameter int unsigned NUM_MODULES = bmcc_pkg::NUM_MODULES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bmcc_pkg::ctrl_type           ctrl,
   input  logic [bmcc_pkg::CMD_W-1:0]   req_cmd,
   input  logic [bmcc_pkg::ADDR_W-1:0]  req_address,
   output logic [bmcc_pkg::IDENT_W-1:0] rsp_chip_ident,
   output logic                         rsp_applied
);

   localparam int unsigned NW = 2 * NUM_MODULES;

   bmcc_pkg::cmd_type                cmd_ff;
   logic [bmcc_pkg::ADDR_W-1:0]      addr_ff;
   logic [bmcc_pkg::COUNT_W-1:0]     count_ff [NUM_MODULES];
   logic [bmcc_pkg::ADDR_W-1:0]      word_ff  [NW];
   logic                             applied_pend_ff;
   logic [bmcc_pkg::IDENT_W-1:0]     ident_ff;
   logic                             applied_ff;

   // First pending controller and first controller whose word 0 matches.
   logic                             cfg_hit, unc_hit;
   logic [bmcc_pkg::MOD_IDX_W-1:0]   cfg_sel, unc_sel;
   logic [bmcc_pkg::IDENT_W-1:0]     ident_in;

   always_comb begin
      cfg_hit  = 1'b0;
      unc_hit  = 1'b0;
      cfg_sel  = '0;
      unc_sel  = '0;
      ident_in = '0;
      for (int i = 0; i < NUM_MODULES; i++) begin
         if (!cfg_hit && count_ff[i] != '0) begin
            cfg_hit  = 1'b1;
            cfg_sel  = bmcc_pkg::MOD_IDX_W'(i);
            ident_in = bmcc_pkg::ident_of(bmcc_pkg::MOD_IDX_W'(i), count_ff[i]);
         end
         if (!unc_hit && word_ff[2*i] == addr_ff) begin
            unc_hit = 1'b1;
            unc_sel = bmcc_pkg::MOD_IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         cmd_ff  <= bmcc_pkg::cmd_type'(req_cmd);
         addr_ff <= req_address;
      end
      if (ctrl.load_rsp) begin
         ident_ff   <= ident_in;
         applied_ff <= applied_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         applied_pend_ff <= 1'b0;
         for (int i = 0; i < NUM_MODULES; i++) begin
            count_ff[i]     <= bmcc_pkg::count_reset(bmcc_pkg::MOD_IDX_W'(i));
            word_ff[2*i]    <= '0;
            word_ff[2*i+1]  <= '0;
         end
      end else if (ctrl.exec) begin
         unique case (cmd_ff)
            bmcc_pkg::CMD_RESET: begin
               applied_pend_ff <= 1'b0;
               for (int i = 0; i < NUM_MODULES; i++) begin
                  count_ff[i]    <= bmcc_pkg::count_reset(bmcc_pkg::MOD_IDX_W'(i));
                  word_ff[2*i]   <= '0;
                  word_ff[2*i+1] <= '0;
               end
            end
            bmcc_pkg::CMD_CONFIGURE: begin
               applied_pend_ff <= cfg_hit;
               for (int i = 0; i < NUM_MODULES; i++) begin
                  if (cfg_hit && cfg_sel == bmcc_pkg::MOD_IDX_W'(i)) begin
                     count_ff[i] <= count_ff[i] - 2'd1;
                     // The new count selects the word; a wrapped count uses its low bit.
                     if (count_ff[i][0]) word_ff[2*i]   <= addr_ff;
                     else                word_ff[2*i+1] <= addr_ff;
                  end
               end
            end
            bmcc_pkg::CMD_UNCONFIGURE: begin
               applied_pend_ff <= unc_hit;
               for (int i = 0; i < NUM_MODULES; i++) begin
                  if (unc_hit && unc_sel == bmcc_pkg::MOD_IDX_W'(i)) begin
                     count_ff[i]    <= bmcc_pkg::count_reset(bmcc_pkg::MOD_IDX_W'(i));
                     word_ff[2*i]   <= '0;
                     word_ff[2*i+1] <= '0;
                  end
               end
            end
            bmcc_pkg::CMD_IDENT: begin
               applied_pend_ff <= 1'b0;
            end
            default: begin
               applied_pend_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_chip_ident = ident_ff;
   assign rsp_applied    = applied_ff;

endmodule

// ===== design/bus_module_config_chain.sv =====
// Configuration chain of the memory-module controllers on a calculator bus. Each
// request beat carries a command (reset chain, configure, unconfigure or read
// identification) and a 20-bit address, and produces exactly one response beat
// with the identifier of the first controller still waiting for configuration
// (0 if none) and a flag that says whether a configure or unconfigure changed a
// controller. A beat is captured, then the datapath applies the command to the
// chain, then the identifier is looked up from the updated counts and loaded as
// the response. The controller sequencer handles one beat at a time, so it takes
// no new request until the last one's result is loaded; a response waiting in the
// output register does not block acceptance of the next request, only the loading
// of its result.
module bus_module_config_chain #(
   parameter int unsigned NUM_MODULES = bmcc_pkg::NUM_MODULES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bmcc_req_if.sink   req_bus,
   bmcc_rsp_if.source rsp_bus
);

   bmcc_pkg::ctrl_type ctrl;

   // The sequencer owns the handshakes and steps each beat through capture,
   // apply and response load.
   bmcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   // The datapath holds the counts and words of every controller and resolves
   // the first qualifying controller in parallel.
   bmcc_datapath #(
      .NUM_MODULES (NUM_MODULES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_cmd        (req_bus.cmd),
      .req_address    (req_bus.address),
      .rsp_chip_ident (rsp_bus.chip_ident),
      .rsp_applied    (rsp_bus.applied)
   );

   // Only one beat is in flight, so acceptance closes the request side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while a beat was in flight");

   // A result is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response register overwritten");

   // The command is applied in the cycle after the beat is captured.
   a_exec_order: assert property (@(posedge clock) disable iff (reset)
      ctrl.latch |=> ctrl.exec)
      else $error("command not applied after capture");

   // Once a command is applied, the next cycle neither captures nor applies.
   a_load_after_exec: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec |=> !ctrl.latch && !ctrl.exec)
      else $error("sequencer left the response step early");

endmodule
